// ----- design/lzss_flag_byte_decoder_assert.svh -----
// Assertion macros shared by the LZSS decoder checker.
`ifndef LZSS_FLAG_BYTE_DECODER_ASSERT_SVH
`define LZSS_FLAG_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LFBD_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LFBD_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lfbd_pkg.sv -----
// Types and constants for the LZSS flag-byte decoder.
package lfbd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int COUNT_WIDTH_DEF  = 24;

  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;
  localparam int OSZ_W  = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  localparam int TOKENS_PER_FLAG = 8;
  localparam int TIDX_W = $clog2(TOKENS_PER_FLAG);
  localparam int LEN_W  = 5;
  localparam logic [3:0] LEN_MASK = 4'h0F;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SIZE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [OSZ_W-1:0]  OSZ_RESET  = 24'd1;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LIT   = 2'd1,
    ST_CP_RD = 2'd2,
    ST_CP_WR = 2'd3
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic lit_emit;
    logic cp_read;
    logic cp_emit;
  } cmd_t;

  typedef struct packed {
    logic start_lit;
    logic start_copy;
    logic copy_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/lfbd_in_if.sv -----
// Compressed byte channel: valid/ready with input payload.
interface lfbd_in_if;
  logic                     valid;
  logic                     ready;
  logic [lfbd_pkg::BYTE_W-1:0] in_byte;
  logic                     new_entry;

  modport source (output valid, in_byte, new_entry, input ready);
  modport sink   (input valid, in_byte, new_entry, output ready);
endinterface

// ----- design/lfbd_out_if.sv -----
// Decompressed byte channel: valid/ready with result payload.
interface lfbd_out_if;
  logic                     valid;
  logic                     ready;
  logic [lfbd_pkg::BYTE_W-1:0] out_byte;
  logic                     last_of_run;
  logic                     end_of_entry;
  logic                     before_start;

  modport source (output valid, out_byte, last_of_run, end_of_entry, before_start,
                  input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_entry, before_start,
                  output ready);
endinterface

// ----- design/lzss_flag_byte_decoder.sv -----
// LZSS flag-byte decoder, 4 KiB history window.
//
// comp_bytes carries compressed bytes (in_byte, new_entry); plain_bytes
// carries decompressed bytes with last_of_run, end_of_entry, before_start.
// Both are valid/ready; a transfer happens when both are high.
// cfg_we/cfg_index/cfg_data write match_mode (0) and output_size (1);
// write them only while the decoder is idle.
// Sequencing: a flag byte or the low byte of a pair is taken while idle,
// with no emit. A literal's transfer is followed by its emit. A pair's high
// byte is followed by a window read and an emit per copied byte, since each
// copied byte is a registered window read followed by the window write of
// the same byte through the single port. Copies give 2..18 bytes, fewer if the
// entry ends first. A literal is emitted from ST_LIT, a copy byte from ST_CP_WR.
// A finished byte sits in an output register; the next input is taken while
// it waits, and the decoder pauses on its next emit until the sink takes it.
// Reset (rst, synchronous) leaves the decoder idle until an item with
// new_entry, sets match_mode 1 and output_size 1. The window is not cleared.
module lzss_flag_byte_decoder #(
  parameter int WINDOW_DEPTH = lfbd_pkg::WINDOW_DEPTH_DEF,
  parameter int COUNT_WIDTH  = lfbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lfbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfbd_pkg::CFG_DATA_W-1:0] cfg_data,
  lfbd_in_if.sink                         comp_bytes,
  lfbd_out_if.source                      plain_bytes
);

  lfbd_pkg::cmd_t cmd;
  lfbd_pkg::sts_t sts;

  lfbd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  lfbd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .comp      (comp_bytes),
    .plain     (plain_bytes),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- design/lfbd_datapath.sv -----
// Datapath: parse registers, history window, counters and output register.
module lfbd_datapath #(
  parameter int WINDOW_DEPTH = lfbd_pkg::WINDOW_DEPTH_DEF,
  parameter int COUNT_WIDTH  = lfbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lfbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  lfbd_in_if.sink                             comp,
  lfbd_out_if.source                          plain,
  input  lfbd_pkg::cmd_t                      cmd,
  output lfbd_pkg::sts_t                      sts
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int DW    = AW + 1;
  localparam int CMP_W = (COUNT_WIDTH > DW) ? COUNT_WIDTH : DW;
  localparam int OSX_W = (COUNT_WIDTH > lfbd_pkg::OSZ_W) ? COUNT_WIDTH : lfbd_pkg::OSZ_W;

  // configuration
  logic [lfbd_pkg::MODE_W-1:0] match_mode;
  logic [lfbd_pkg::OSZ_W-1:0]  output_size;

  // parse state
  logic [lfbd_pkg::BYTE_W-1:0] flags;
  logic [lfbd_pkg::TIDX_W-1:0] tidx;
  lfbd_pkg::phase_t            phase;
  logic [lfbd_pkg::BYTE_W-1:0] pair_low;
  logic                        done;
  logic [AW-1:0]               wp;
  logic [COUNT_WIDTH-1:0]      pc;

  // work registers
  logic [lfbd_pkg::BYTE_W-1:0] lit_byte;
  logic [lfbd_pkg::LEN_W-1:0]  remain;
  logic [DW-1:0]               cp_dist;
  logic [lfbd_pkg::BYTE_W-1:0] rdata;

  logic [lfbd_pkg::BYTE_W-1:0] window [WINDOW_DEPTH];

  // output register
  logic                        out_valid;
  logic [lfbd_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;
  logic                        out_eoe;
  logic                        out_bs;

  logic                        take;
  logic [OSX_W-1:0]            osz_ext;
  logic [COUNT_WIDTH-1:0]      osz_cnt;
  logic                        osz_zero;
  lfbd_pkg::phase_t            eff_phase;
  logic [lfbd_pkg::BYTE_W-1:0] eff_flags;
  logic [lfbd_pkg::TIDX_W-1:0] eff_tidx;
  logic [lfbd_pkg::BYTE_W-1:0] eff_pl;
  logic                        eff_done;
  logic [lfbd_pkg::TIDX_W-1:0] tidx_inc;
  logic                        tok_bit;
  logic [lfbd_pkg::LEN_W-1:0]  mode_eff;
  logic [lfbd_pkg::LEN_W-1:0]  len_calc;
  logic [DW-1:0]               dist_calc;
  logic [AW-1:0]               raddr;
  logic                        emit;
  logic                        bs;
  logic [lfbd_pkg::BYTE_W-1:0] emit_byte;
  logic [COUNT_WIDTH-1:0]      pc_inc;
  logic                        eoe;
  logic                        run_last;

  always_comb begin
    take      = comp.valid & cmd.in_rdy;
    osz_ext   = OSX_W'(output_size);
    osz_cnt   = osz_ext[COUNT_WIDTH-1:0];
    osz_zero  = (osz_cnt == '0);
    eff_phase = comp.new_entry ? lfbd_pkg::PH_FLAG : phase;
    eff_flags = comp.new_entry ? '0 : flags;
    eff_tidx  = comp.new_entry ? '0 : tidx;
    eff_pl    = comp.new_entry ? '0 : pair_low;
    eff_done  = comp.new_entry ? osz_zero : done;
    tidx_inc  = eff_tidx + 1'b1;
    tok_bit   = eff_flags[eff_tidx];
    // modes 0 and 3 clamp into 1..2
    case (match_mode)
      2'd0, 2'd1: mode_eff = lfbd_pkg::LEN_W'(1);
      default:    mode_eff = lfbd_pkg::LEN_W'(2);
    endcase
    len_calc  = lfbd_pkg::LEN_W'(eff_pl[3:0] & lfbd_pkg::LEN_MASK) + mode_eff
                + lfbd_pkg::LEN_W'(1);
    dist_calc = DW'({comp.in_byte, eff_pl[7:4]}) + DW'(1);

    raddr     = wp - cp_dist[AW-1:0];
    emit      = cmd.lit_emit | cmd.cp_emit;
    bs        = cmd.cp_emit & (CMP_W'(cp_dist) > CMP_W'(pc));
    emit_byte = cmd.lit_emit ? lit_byte : (bs ? '0 : rdata);
    pc_inc    = pc + 1'b1;
    eoe       = (pc_inc == osz_cnt);
    run_last  = (remain == lfbd_pkg::LEN_W'(1)) | eoe;

    sts.start_lit  = take & ~eff_done & (eff_phase == lfbd_pkg::PH_TOKEN) & tok_bit;
    sts.start_copy = take & ~eff_done & (eff_phase == lfbd_pkg::PH_HIGH);
    sts.copy_last  = run_last;
    sts.out_free   = ~out_valid | plain.ready;
  end

  assign comp.ready         = cmd.in_rdy;
  assign plain.valid        = out_valid;
  assign plain.out_byte     = out_byte;
  assign plain.last_of_run  = out_last;
  assign plain.end_of_entry = out_eoe;
  assign plain.before_start = out_bs;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode  <= lfbd_pkg::MODE_RESET;
      output_size <= lfbd_pkg::OSZ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lfbd_pkg::CFG_MATCH_MODE:  match_mode  <= cfg_data[lfbd_pkg::MODE_W-1:0];
        lfbd_pkg::CFG_OUTPUT_SIZE: output_size <= cfg_data[lfbd_pkg::OSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      tidx     <= '0;
      phase    <= lfbd_pkg::PH_FLAG;
      pair_low <= '0;
      done     <= 1'b1;
      wp       <= '0;
      pc       <= '0;
    end else if (take) begin
      if (comp.new_entry) begin
        flags    <= '0;
        tidx     <= '0;
        phase    <= lfbd_pkg::PH_FLAG;
        pair_low <= '0;
        wp       <= '0;
        pc       <= '0;
      end
      done <= eff_done;
      if (!eff_done) begin
        case (eff_phase)
          lfbd_pkg::PH_TOKEN: begin
            if (tok_bit) begin
              tidx  <= tidx_inc;
              phase <= (tidx_inc == '0) ? lfbd_pkg::PH_FLAG : lfbd_pkg::PH_TOKEN;
            end else begin
              pair_low <= comp.in_byte;
              phase    <= lfbd_pkg::PH_HIGH;
            end
          end
          lfbd_pkg::PH_HIGH: begin
            tidx  <= tidx_inc;
            phase <= (tidx_inc == '0) ? lfbd_pkg::PH_FLAG : lfbd_pkg::PH_TOKEN;
          end
          default: begin
            flags <= comp.in_byte;
            tidx  <= '0;
            phase <= lfbd_pkg::PH_TOKEN;
          end
        endcase
      end
    end else if (emit) begin
      wp <= wp + 1'b1;
      pc <= pc_inc;
      if (eoe) done <= 1'b1;
    end
  end

  // token work registers, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      lit_byte <= comp.in_byte;
      remain   <= len_calc;
      cp_dist  <= dist_calc;
    end else if (cmd.cp_emit) begin
      remain <= remain - 1'b1;
    end
  end

  // history window: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (emit) window[wp] <= emit_byte;
    if (cmd.cp_read) rdata <= window[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (plain.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= cmd.lit_emit | run_last;
      out_eoe  <= eoe;
      out_bs   <= bs;
    end
  end

endmodule

// ----- design/lfbd_ctrl.sv -----
// Controller: sequences input acceptance, literal emit and copy loop.
module lfbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  lfbd_pkg::sts_t  sts,
  output lfbd_pkg::cmd_t  cmd
);

  lfbd_pkg::state_t state;
  lfbd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      lfbd_pkg::ST_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.start_lit) begin
          state_next = lfbd_pkg::ST_LIT;
        end else if (sts.start_copy) begin
          state_next = lfbd_pkg::ST_CP_RD;
        end
      end
      lfbd_pkg::ST_LIT: begin
        if (sts.out_free) begin
          cmd.lit_emit = 1'b1;
          state_next   = lfbd_pkg::ST_IDLE;
        end
      end
      lfbd_pkg::ST_CP_RD: begin
        cmd.cp_read = 1'b1;
        state_next  = lfbd_pkg::ST_CP_WR;
      end
      lfbd_pkg::ST_CP_WR: begin
        if (sts.out_free) begin
          cmd.cp_emit = 1'b1;
          state_next  = sts.copy_last ? lfbd_pkg::ST_IDLE : lfbd_pkg::ST_CP_RD;
        end
      end
      default: state_next = lfbd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- design/lfbd_checker.sv -----
// Port-level checks for the LZSS decoder, bound to the top level.
`include "lzss_flag_byte_decoder_assert.svh"

module lfbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lfbd_pkg::BYTE_W-1:0] out_byte,
  input logic                        last_of_run,
  input logic                        end_of_entry,
  input logic                        before_start
);

  `LFBD_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run), "stalled result changed")
  `LFBD_AST_IMP(a_eoe_last, out_valid && end_of_entry, last_of_run, "end of entry not last of run")
  `LFBD_AST_IMP(a_bs_zero, out_valid && before_start, out_byte == '0, "before-start byte not zero")
  `LFBD_AST_IMP(a_busy_copy, out_valid && !last_of_run, !(in_valid && in_ready), "input taken during a copy")
  `LFBD_AST_IMP(a_reset_quiet, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind lzss_flag_byte_decoder lfbd_checker u_lfbd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (comp_bytes.valid),
  .in_ready     (comp_bytes.ready),
  .out_valid    (plain_bytes.valid),
  .out_ready    (plain_bytes.ready),
  .out_byte     (plain_bytes.out_byte),
  .last_of_run  (plain_bytes.last_of_run),
  .end_of_entry (plain_bytes.end_of_entry),
  .before_start (plain_bytes.before_start)
);

// ----- tb/lzss_flag_byte_decoder_checker.sv -----
// Checker for the LZSS decoder: predicts decompressed bytes and compares transfers.
module lzss_flag_byte_decoder_checker
  import lfbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfbd_in_if                    comp_bytes,
  lfbd_out_if                   plain_bytes,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eoe;
    logic              bs;
  } plain_rec_t;

  logic [BYTE_W-1:0]          hist [WINDOW_DEPTH_DEF];
  logic [11:0]                wpos;
  logic [COUNT_WIDTH_DEF-1:0] produced;
  logic [7:0]                 tok_flags;
  logic [TIDX_W-1:0]          tok_idx;
  phase_t                     parse_ph;
  logic [7:0]                 pair_lo;
  bit                         done;
  logic [MODE_W-1:0]          mode_reg;
  logic [OSZ_W-1:0]           osize;
  plain_rec_t                 plain_q [$];
  int                         err_cnt;

  initial begin
    err_cnt = 0;
  end

  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic bs);
    plain_rec_t r;
    hist[wpos] = b;
    wpos = wpos + 12'd1;
    produced = produced + 1'b1;
    r.data = b;
    r.last = 1'b0;
    r.eoe  = (produced == osize);
    r.bs   = bs;
    if (r.eoe) done = 1'b1;
    plain_q.push_back(r);
  endtask

  task automatic next_token();
    tok_idx = tok_idx + 1'b1;
    parse_ph = (tok_idx == 0) ? PH_FLAG : PH_TOKEN;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic ne);
    int          n0;
    int          len;
    logic [12:0] back_dist;
    logic [15:0] pair;
    logic [1:0]  m;
    plain_rec_t  tail;
    n0 = plain_q.size();
    if (ne) begin
      wpos      = '0;
      produced  = '0;
      tok_flags = '0;
      tok_idx   = '0;
      pair_lo   = '0;
      parse_ph  = PH_FLAG;
      done      = (osize == 0);
    end
    if (!done) begin
      case (parse_ph)
        PH_TOKEN: begin
          if (tok_flags[tok_idx]) begin
            put_byte(b, 1'b0);
            next_token();
          end else begin
            pair_lo  = b;
            parse_ph = PH_HIGH;
          end
        end
        PH_HIGH: begin
          pair = {b, pair_lo};
          // modes 0 and 3 clamp to 1 and 2
          m    = (mode_reg == 2'd0) ? 2'd1 : (mode_reg == 2'd3) ? 2'd2 : mode_reg;
          len  = int'(pair[3:0] & LEN_MASK) + int'(m) + 1;
          back_dist = {1'b0, pair[15:4]} + 13'd1;
          for (int i = 0; i < len && !done; i++) begin
            if (COUNT_WIDTH_DEF'(back_dist) > produced) put_byte('0, 1'b1);
            else put_byte(hist[wpos - back_dist[11:0]], 1'b0);
          end
          next_token();
        end
        default: begin
          tok_flags = b;
          tok_idx   = '0;
          parse_ph  = PH_TOKEN;
        end
      endcase
      if (plain_q.size() > n0) begin
        tail = plain_q.pop_back();
        tail.last = 1'b1;
        plain_q.push_back(tail);
      end
    end
  endtask

  always @(posedge clk) begin
    plain_rec_t got;
    plain_rec_t want;
    if (rst) begin
      wpos      = '0;
      produced  = '0;
      tok_flags = '0;
      tok_idx   = '0;
      pair_lo   = '0;
      parse_ph  = PH_FLAG;
      done      = 1'b1;
      mode_reg  = MODE_RESET;
      osize     = OSZ_RESET;
      plain_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATCH_MODE:  mode_reg = cfg_data[MODE_W-1:0];
          CFG_OUTPUT_SIZE: osize    = cfg_data[OSZ_W-1:0];
          default: ;
        endcase
      end
      if (plain_bytes.valid && plain_bytes.ready) begin
        got.data = plain_bytes.out_byte;
        got.last = plain_bytes.last_of_run;
        got.eoe  = plain_bytes.end_of_entry;
        got.bs   = plain_bytes.before_start;
        if (plain_q.size() == 0) begin
          if (err_cnt < 10)
            $display("plain_bytes: unexpected transfer, byte %h last %b end %b before %b",
                     got.data, got.last, got.eoe, got.bs);
          err_cnt++;
        end else begin
          want = plain_q.pop_front();
          if (got !== want) begin
            if (err_cnt < 10)
              $display({"plain_bytes mismatch: expected byte %h last %b end %b before %b,",
                        " got byte %h last %b end %b before %b"},
                       want.data, want.last, want.eoe, want.bs,
                       got.data, got.last, got.eoe, got.bs);
            err_cnt++;
          end
        end
      end
      if (comp_bytes.valid && comp_bytes.ready)
        decode_byte(comp_bytes.in_byte, comp_bytes.new_entry);
    end
    errors  <= err_cnt;
    pending <= plain_q.size();
  end

endmodule

// ----- tb/lzss_flag_byte_decoder_tb.sv -----
// Testbench top for the LZSS decoder: clock, reset, stimulus and verdict.
module lzss_flag_byte_decoder_tb;
  import lfbd_pkg::*;

  localparam int SETTLE_CYCLES  = 45;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 9;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lfbd_in_if  comp_bytes ();
  lfbd_out_if plain_bytes ();

  int mismatches;
  int awaiting;
  int idle_cycles = 0;
  int sent_items;
  int cur_mode;
  int cur_osize;
  bit src_steady;
  bit sink_steady;

  lzss_flag_byte_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .comp_bytes  (comp_bytes),
    .plain_bytes (plain_bytes)
  );

  lzss_flag_byte_decoder_checker plain_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .comp_bytes  (comp_bytes),
    .plain_bytes (plain_bytes),
    .errors      (mismatches),
    .pending     (awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int hold;
    hold = 0;
    plain_bytes.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        if (sink_steady || $urandom_range(0, 2) != 0) begin
          plain_bytes.ready <= 1'b1;
          hold = $urandom_range(1, 12);
        end else begin
          plain_bytes.ready <= 1'b0;
          hold = pick_pause();
          if (hold == 0) hold = 1;
        end
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (comp_bytes.valid && comp_bytes.ready) ||
        (plain_bytes.valid && plain_bytes.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ne);
    int gap;
    gap = src_steady ? 0 : pick_pause();
    if (gap > 0) begin
      comp_bytes.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    comp_bytes.valid     <= 1'b1;
    comp_bytes.in_byte   <= b;
    comp_bytes.new_entry <= ne;
    @(posedge clk);
    while (!comp_bytes.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic hold_for_results();
    comp_bytes.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // byte-free items may still be in flight once the last byte is out
  task automatic quiesce();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int mode_val, input int size_val);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MATCH_MODE;
    cfg_data  <= CFG_DATA_W'(mode_val);
    @(posedge clk);
    cfg_index <= CFG_OUTPUT_SIZE;
    cfg_data  <= CFG_DATA_W'(size_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = mode_val;
    cur_osize = size_val;
  endtask

  // One entry: flag bytes, literals and pairs that mostly point inside the entry.
  task automatic send_entry(input int ntok, input int lit_pct);
    int          made;
    int          eff;
    int          nib;
    int          span;
    int          reach;
    logic [7:0]  flag_bits;
    logic [15:0] pair;
    made = 0;
    eff  = (cur_mode == 0) ? 1 : (cur_mode == 3) ? 2 : cur_mode;
    flag_bits = '0;
    for (int k = 0; k < ntok; k++) begin
      if (cur_osize != 0 && made >= cur_osize) break;
      if (k % 8 == 0) begin
        for (int b = 0; b < 8; b++) flag_bits[b] = ($urandom_range(0, 99) < lit_pct);
        send_byte(flag_bits, k == 0);
      end
      if (flag_bits[k % 8]) begin
        send_byte(8'($urandom), 1'b0);
        made++;
      end else begin
        nib   = $urandom_range(0, 15);
        reach = (made < 4096) ? made : 4096;
        if (reach == 0 || $urandom_range(0, 9) == 0) span = $urandom_range(1, 4096);
        else span = $urandom_range(1, reach);
        pair = {12'(span - 1), 4'(nib)};
        send_byte(pair[7:0], 1'b0);
        // occasionally abandon the pair after its low byte
        if ($urandom_range(0, 39) == 0) break;
        send_byte(pair[15:8], 1'b0);
        made += nib + eff + 1;
      end
    end
  endtask

  initial begin
    int target;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_MATCH_MODE;
    cfg_data             <= '0;
    comp_bytes.valid     <= 1'b0;
    comp_bytes.in_byte   <= '0;
    comp_bytes.new_entry <= 1'b0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    sent_items  = 0;
    cur_mode    = int'(MODE_RESET);
    cur_osize   = int'(OSZ_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle after reset, then a one-byte entry under reset settings
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // mode 0 acts as 1: overlapping copy, far reference, truncated tail
    configure(0, 40);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h2F, 1'b0);
    send_byte(8'h00, 1'b0);
    hold_for_results();

    // zero size entry with mode 3
    configure(3, 0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);

    // largest size: copies from before the entry, one straddling its start
    configure(2, 24'hFFFFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h80, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(1, $urandom_range(16, 120));
        1: configure(2, $urandom_range(1, 8));
        2: configure(0, $urandom_range(30, 200));
        3: configure(3, $urandom_range(50, 300));
        4: configure(1, 2);
        default: configure(2, 24'hFFFFFF);
      endcase
      src_steady  = (p == 2);
      sink_steady = (p == 2);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) == 0)
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        else
          send_entry($urandom_range(2, 24), $urandom_range(20, 80));
        if ($urandom_range(0, 5) == 0) hold_for_results();
      end
    end

    // copy-heavy entry from a steady source
    src_steady  = 1'b1;
    sink_steady = 1'b0;
    configure(2, 300);
    send_entry(12, 15);

    quiesce();
    if (mismatches == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
